### rtl/core/mh_pkg.sv
package mh_pkg;

    localparam int ROTATION_STAGES     = 16;
    localparam int ANGLE_FRACTION_BITS = 7;

    localparam int TABLE_LEN = 24;
    localparam int STAGES    = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    localparam int PRESCALE = 8;
    localparam int ANG_FRAC = 16;
    // vector magnitude grows by about 1.65 over the chain
    localparam int XW = 27;
    // angle accumulator, degrees with ANG_FRAC fraction bits
    localparam int ZW = 27;
    // reduced angle, below 360 degrees
    localparam int HW = 25;

    localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * (2 ** ANG_FRAC));
    localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 * (2 ** ANG_FRAC));

    localparam int RND_SHIFT = ANG_FRAC - ANGLE_FRACTION_BITS;
    localparam logic [HW:0] RND_BIAS = (HW+1)'(2 ** (RND_SHIFT - 1));
    localparam logic [HW:0] FULL_TURN = (HW+1)'(360 * (2 ** ANGLE_FRACTION_BITS));

    // round(atan(2^-i) degrees * 2^16)
    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    typedef struct packed {
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] z_low;
        logic [7:0] z_high;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic        [15:0] heading;
    } result_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic signed [15:0]   axis_x;
        logic signed [15:0]   axis_y;
        logic signed [15:0]   axis_z;
    } rot_t;

    function automatic logic signed [ZW-1:0] atan_angle(input logic [IDX_W-1:0] idx);
        return ATAN_TAB[idx];
    endfunction

endpackage

### rtl/core/magnetometer_heading.sv
// compass heading from one raw three-axis magnetometer sample
//
// sample channel: sample_valid, sample_stall, sample carries the six raw bytes
// (low byte first per axis). a transaction happens on a clock edge with
// sample_valid high and sample_stall low.
// result channel: result_valid, result_stall, result carries the assembled
// signed X, Y, Z values and the heading in degrees times 128, in [0, 360).
//
// a sample passes one fold register, one cell per rotation stage (16) and
// one rounding/output register on its way to result_valid.
// throughput is one sample per cycle while no stage is held; every stage
// of the cell row moves in each cycle unless the stage ahead of it is full
// and held.
// when result_stall is high the result register holds its value; stages
// behind it keep moving until they fill, so empty slots are squeezed out
// before sample_stall rises.
// reset empties the row of cells; no result is pending after reset.
module magnetometer_heading (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  mh_pkg::sample_t  sample,
    output logic             result_valid,
    input  logic             result_stall,
    output mh_pkg::result_t  result
);

    logic         valid [mh_pkg::STAGES+1];
    logic         hold  [mh_pkg::STAGES+1];
    mh_pkg::rot_t data  [mh_pkg::STAGES+1];
    logic         fold_hold;

    mh_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_data   (sample),
        .up_hold   (fold_hold),
        .out_valid (valid[0]),
        .out_data  (data[0]),
        .down_hold (hold[0])
    );

    assign sample_stall = fold_hold;

    for (genvar k = 0; k < mh_pkg::STAGES; k++)
    begin : g_cell
        mh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (mh_pkg::IDX_W'(k)),
            .in_valid  (valid[k]),
            .in_data   (data[k]),
            .up_hold   (hold[k]),
            .out_valid (valid[k+1]),
            .out_data  (data[k+1]),
            .down_hold (hold[k+1])
        );
    end

    mh_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[mh_pkg::STAGES]),
        .in_data   (data[mh_pkg::STAGES]),
        .up_hold   (hold[mh_pkg::STAGES]),
        .out_valid (result_valid),
        .out_data  (result),
        .out_stall (result_stall)
    );

endmodule

### rtl/core/mh_fold.sv
module mh_fold (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mh_pkg::sample_t  in_data,
    output logic             up_hold,
    output logic             out_valid,
    output mh_pkg::rot_t     out_data,
    input  logic             down_hold
);

    logic              valid_reg;
    mh_pkg::rot_t      data_reg;
    mh_pkg::rot_t      data_next;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [mh_pkg::XW-1:0] xs;
    logic signed [mh_pkg::XW-1:0] ys;

    assign up_hold = valid_reg && down_hold;

    always_comb
    begin
        ax = {in_data.x_high, in_data.x_low};
        ay = {in_data.y_high, in_data.y_low};
        xs = mh_pkg::XW'(ax) <<< mh_pkg::PRESCALE;
        ys = mh_pkg::XW'(ay) <<< mh_pkg::PRESCALE;
        data_next.axis_x = ax;
        data_next.axis_y = ay;
        data_next.axis_z = {in_data.z_high, in_data.z_low};
        data_next.zero   = (ax == 16'sd0) && (ay == 16'sd0);
        // left half plane: rotate by 180 degrees first
        if (ax < 0)
        begin
            data_next.x = -xs;
            data_next.y = -ys;
            data_next.z = mh_pkg::DEG_180;
        end
        else
        begin
            data_next.x = xs;
            data_next.y = ys;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !up_hold)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/mh_cell.sv
module mh_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mh_pkg::IDX_W-1:0]    stage,
    input  logic                        in_valid,
    input  mh_pkg::rot_t                in_data,
    output logic                        up_hold,
    output logic                        out_valid,
    output mh_pkg::rot_t                out_data,
    input  logic                        down_hold
);

    logic                         valid_reg;
    mh_pkg::rot_t                 data_reg;
    mh_pkg::rot_t                 data_next;
    logic signed [mh_pkg::XW-1:0] dx;
    logic signed [mh_pkg::XW-1:0] dy;
    logic signed [mh_pkg::ZW-1:0] angle;

    assign up_hold = valid_reg && down_hold;

    always_comb
    begin
        dx    = in_data.y >>> stage;
        dy    = in_data.x >>> stage;
        angle = mh_pkg::atan_angle(stage);
        data_next = in_data;
        // drive y toward zero
        if (!in_data.y[mh_pkg::XW-1] && (in_data.y != '0))
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + angle;
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !up_hold)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/mh_finish.sv
module mh_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mh_pkg::rot_t     in_data,
    output logic             up_hold,
    output logic             out_valid,
    output mh_pkg::result_t  out_data,
    input  logic             out_stall
);

    logic                         valid_reg;
    mh_pkg::result_t              data_reg;
    mh_pkg::result_t              data_next;
    logic signed [mh_pkg::ZW-1:0] neg_z;
    logic signed [mh_pkg::ZW-1:0] wrapped;
    logic        [mh_pkg::HW:0]   rounded;

    assign up_hold = valid_reg && out_stall;

    always_comb
    begin
        neg_z = -in_data.z;
        wrapped = neg_z[mh_pkg::ZW-1] ? (neg_z + mh_pkg::DEG_360) : neg_z;
        rounded = ({1'b0, wrapped[mh_pkg::HW-1:0]} + mh_pkg::RND_BIAS) >> mh_pkg::RND_SHIFT;
        data_next.axis_x = in_data.axis_x;
        data_next.axis_y = in_data.axis_y;
        data_next.axis_z = in_data.axis_z;
        // a value that rounds up to a full turn wraps to zero
        if (in_data.zero || (rounded >= mh_pkg::FULL_TURN))
        begin
            data_next.heading = '0;
        end
        else
        begin
            data_next.heading = rounded[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !up_hold)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
